[rtl/tstp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstp_pkg: shared types and constants of the touch swipe/tap pager
// Item and result layouts, the request kinds, register map and reset values.
// ----------------------------------------------------------------------------
package tstp_pkg;

  // number of pages of the looping pager
  localparam int unsigned PageTotal = 6;
  // default depth of the queue between the front and the back part
  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned CoordW = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PageW  = 4;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned InDataW  = 56;  // 10 + 10 + 32, padded to bytes
  localparam int unsigned OutDataW = 16;  // 4 + 5 flags, padded to bytes
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // request codes on the input stream
  typedef enum logic [ReqW-1:0] {
    REQ_PRESSED  = 3'd0,
    REQ_MOVING   = 3'd1,
    REQ_RELEASED = 3'd2,
    REQ_LOST     = 3'd3,
    REQ_DONE     = 3'd4
  } tstp_req_e;

  // classified item kinds; release and press lost behave alike
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PRESS,
    KIND_MOVE,
    KIND_END,
    KIND_DONE
  } tstp_kind_e;

  // configuration register map
  typedef enum logic [CfgAddrW-1:0] {
    CFG_SWIPE_MIN_TRAVEL = 3'd0,
    CFG_AXIS_RATIO       = 3'd1,
    CFG_TAP_TIME_LIMIT   = 3'd2,
    CFG_TAP_MAX_TRAVEL   = 3'd3,
    CFG_STRICT_PAGE      = 3'd4,
    CFG_PAGER_ENABLED    = 3'd5
  } tstp_cfg_addr_e;

  localparam logic [9:0]  SwipeMinTravelRst = 10'd40;
  localparam logic [3:0]  AxisRatioRst      = 4'd2;
  localparam logic [15:0] TapTimeLimitRst   = 16'd250;
  localparam logic [9:0]  TapMaxTravelRst   = 10'd12;
  localparam logic [3:0]  StrictPageRst     = 4'd0;
  localparam logic        PagerEnabledRst   = 1'b1;

  typedef struct packed {
    logic [9:0]  swipe_min_travel;
    logic [3:0]  axis_ratio;
    logic [15:0] tap_time_limit;
    logic [9:0]  tap_max_travel;
    logic [3:0]  strict_page;
    logic        pager_enabled;
  } tstp_cfg_t;

  typedef struct packed {
    tstp_kind_e        kind;
    logic [CoordW-1:0] touch_x;
    logic [CoordW-1:0] touch_y;
    logic [TimeW-1:0]  time_ms;
  } tstp_item_t;

  typedef struct packed {
    logic              busy_res;
    logic              tap_detected;
    logic              swipe_seen;
    logic              step_forward;
    logic              page_changed;
    logic [PageW-1:0]  page_index;
  } tstp_result_t;

endpackage

[rtl/tstp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstp_front: input stage of the pager
// Accepts stream items, classifies the request code and feeds the queue.
// ----------------------------------------------------------------------------
module tstp_front import tstp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ReqW-1:0]     in_req_i,
  input  logic [InDataW-1:0]  in_data_i,
  output logic                push_o,
  output tstp_item_t          item_o,
  input  logic                full_i
);

  logic       valid_q, valid_d;
  tstp_item_t item_q, item_d;
  tstp_kind_e kind;

  always_comb begin
    case (in_req_i)
      REQ_PRESSED:  kind = KIND_PRESS;
      REQ_MOVING:   kind = KIND_MOVE;
      REQ_RELEASED: kind = KIND_END;
      REQ_LOST:     kind = KIND_END;
      REQ_DONE:     kind = KIND_DONE;
      default:      kind = KIND_NONE;
    endcase
  end

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d         = 1'b1;
      item_d.kind     = kind;
      item_d.touch_x  = in_data_i[CoordW-1:0];
      item_d.touch_y  = in_data_i[2*CoordW-1:CoordW];
      item_d.time_ms  = in_data_i[2*CoordW+TimeW-1:2*CoordW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

[rtl/tstp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstp_queue: short item queue between front and back
// Circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tstp_queue import tstp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tstp_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output tstp_item_t item_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tstp_item_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/tstp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstp_back: gesture engine and press/swipe/page state of the pager
// Pops one item a cycle unless output stalls; updates state, registers result.
// ----------------------------------------------------------------------------
module tstp_back import tstp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tstp_cfg_t     cfg_i,
  input  logic          empty_i,
  input  tstp_item_t    item_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tstp_result_t  result_o
);

  logic              pressed_q, pressed_d;
  logic              swiped_q, swiped_d;
  logic              busy_q, busy_d;
  logic [PageW-1:0]  page_q, page_d;
  logic [CoordW-1:0] start_x_q, start_y_q;
  logic [TimeW-1:0]  start_time_q;
  logic              out_valid_q, out_valid_d;
  tstp_result_t      result_q, result_d;

  logic              left;
  logic [CoordW-1:0] adx, ady, travel;
  logic              strict;
  logic [CoordW:0]   min_dx;
  logic [4:0]        ratio;
  logic [14:0]       ratio_dy;
  logic [TimeW-1:0]  dur;
  logic              commit;
  logic              tap;
  logic [PageW-1:0]  page_next, page_prev;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    left   = item_i.touch_x < start_x_q;
    adx    = left ? start_x_q - item_i.touch_x : item_i.touch_x - start_x_q;
    ady    = (item_i.touch_y < start_y_q) ? start_y_q - item_i.touch_y
                                          : item_i.touch_y - start_y_q;
    travel = (adx > ady) ? adx : ady;
    strict = (page_q == cfg_i.strict_page);
    // strict bar: 3/2 of the minimum, rounded down, and twice the ratio
    min_dx = strict ? {1'b0, cfg_i.swipe_min_travel} + {2'b0, cfg_i.swipe_min_travel[9:1]}
                    : {1'b0, cfg_i.swipe_min_travel};
    ratio  = strict ? {cfg_i.axis_ratio, 1'b0} : {1'b0, cfg_i.axis_ratio};
    ratio_dy = ratio * ady;
    dur    = item_i.time_ms - start_time_q;
    commit = (item_i.kind == KIND_MOVE) && pressed_q && !swiped_q && !busy_q
             && ({1'b0, adx} >= min_dx) && ({5'b0, adx} > ratio_dy);
    tap    = (item_i.kind == KIND_END) && pressed_q && !swiped_q
             && (dur <= {16'b0, cfg_i.tap_time_limit}) && (travel <= cfg_i.tap_max_travel);
    page_next = (page_q == PageW'(PageTotal - 1)) ? '0 : page_q + 1'b1;
    page_prev = (page_q == '0) ? PageW'(PageTotal - 1) : page_q - 1'b1;
  end

  always_comb begin
    pressed_d   = pressed_q;
    swiped_d    = swiped_q;
    busy_d      = busy_q;
    page_d      = page_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      result_d.page_changed = 1'b0;
      result_d.step_forward = 1'b0;
      case (item_i.kind)
        KIND_PRESS: begin
          pressed_d = 1'b1;
          swiped_d  = 1'b0;
        end
        KIND_DONE: begin
          busy_d = 1'b0;
        end
        KIND_MOVE: begin
          if (commit) begin
            swiped_d = 1'b1;
            if (cfg_i.pager_enabled) begin
              page_d = left ? page_next : page_prev;
              busy_d = 1'b1;
              result_d.page_changed = 1'b1;
              result_d.step_forward = left;
            end
          end
        end
        KIND_END: begin
          pressed_d = 1'b0;
        end
        default: begin
        end
      endcase
      out_valid_d           = 1'b1;
      result_d.page_index   = page_d;
      result_d.swipe_seen   = swiped_d;
      result_d.tap_detected = tap;
      result_d.busy_res     = busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q   <= 1'b0;
      swiped_q    <= 1'b0;
      busy_q      <= 1'b0;
      page_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pressed_q   <= pressed_d;
      swiped_q    <= swiped_d;
      busy_q      <= busy_d;
      page_q      <= page_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (pop_o && item_i.kind == KIND_PRESS) begin
      start_x_q    <= item_i.touch_x;
      start_y_q    <= item_i.touch_y;
      start_time_q <= item_i.time_ms;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[rtl/touch_swipe_tap_pager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_swipe_tap_pager: touch gesture detector driving a looping pager
// Classifies press/move/release events into swipes and taps, keeps the page.
// ----------------------------------------------------------------------------
// Every input item (press, move, release, press lost, transition done, or an
// unknown code) gives exactly one result item with the page index after the
// event, a page-step flag and its direction, the swipe flag of the current or
// last press, a tap flag and the busy flag. The block sustains one item per
// clock while the result stream does not stall; an accepted item passes the
// front register, a queue write and the result register before its result
// is valid. The front part registers and classifies the request code, a
// short queue decouples it from the back part, which holds all gesture state
// and evaluates one item per cycle; while a result waits on a stalled
// downstream side the back part holds, and the front keeps accepting items
// as long as the queue has room. A swipe is committed on a move when
// horizontal travel reaches the minimum and exceeds the ratio times vertical
// travel; on the strict page the minimum is 3/2 of the setting and the ratio
// doubled. Configuration writes are always taken (cfg_ready_o stays high)
// and must only be issued while the block is idle; indexes six and seven are
// ignored.
// ----------------------------------------------------------------------------
module touch_swipe_tap_pager import tstp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // touch_x, touch_y, time_ms, pad
  input  logic [ReqW-1:0]     s_axis_tuser,   // req_type
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // page_index, page_changed, step_forward, swipe_seen, tap_detected,
  // busy_res, pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tstp_cfg_t    cfg_q, cfg_d;
  logic         push;
  tstp_item_t   front_item;
  tstp_item_t   queue_item;
  logic         queue_full;
  logic         queue_empty;
  logic         pop;
  logic [$clog2(QueueDepth+1)-1:0] queue_count;
  tstp_result_t result;

  // ---------------- configuration registers ----------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (tstp_cfg_addr_e'(cfg_addr_i))
        CFG_SWIPE_MIN_TRAVEL: cfg_d.swipe_min_travel = cfg_data_i[9:0];
        CFG_AXIS_RATIO:       cfg_d.axis_ratio       = cfg_data_i[3:0];
        CFG_TAP_TIME_LIMIT:   cfg_d.tap_time_limit   = cfg_data_i;
        CFG_TAP_MAX_TRAVEL:   cfg_d.tap_max_travel   = cfg_data_i[9:0];
        CFG_STRICT_PAGE:      cfg_d.strict_page      = cfg_data_i[3:0];
        CFG_PAGER_ENABLED:    cfg_d.pager_enabled    = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swipe_min_travel <= SwipeMinTravelRst;
      cfg_q.axis_ratio       <= AxisRatioRst;
      cfg_q.tap_time_limit   <= TapTimeLimitRst;
      cfg_q.tap_max_travel   <= TapMaxTravelRst;
      cfg_q.strict_page      <= StrictPageRst;
      cfg_q.pager_enabled    <= PagerEnabledRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- front: accept and classify ----------------
  tstp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (queue_full)
  );

  // ---------------- decoupling queue ----------------
  tstp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .item_o  (queue_item),
    .count_o (queue_count)
  );

  // ---------------- back: gesture engine and page state ----------------
  tstp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (queue_empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  // result packing, page index in the lowest bits
  assign m_axis_tdata = {{(OutDataW - $bits(tstp_result_t)){1'b0}}, result};

  // ---------------- checks ----------------
  // a page step always sets busy and the swipe flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result.page_changed |-> result.busy_res && result.swipe_seen)
    else $error("page step without busy or swipe flag");

  // a forward direction is only reported with a page step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result.step_forward |-> result.page_changed)
    else $error("step direction without page step");

  // a tap never follows a committed swipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result.tap_detected |-> !result.swipe_seen)
    else $error("tap reported after a swipe");

  // the page index stays inside the page range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> result.page_index <= PageW'(PageTotal - 1))
    else $error("page index out of range");

  // the queue is never popped empty nor pushed full without a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && queue_count == '0) && !(push && queue_full && !pop))
    else $error("queue overrun or underrun");

endmodule
